/* hw/rtl/price_level_order_book_defines.svh */
// ----------------------------------------------------------------------------
// price_level_order_book_defines
// Assertion macros used by the order book checker.
// ----------------------------------------------------------------------------
`ifndef PRICE_LEVEL_ORDER_BOOK_DEFINES_SVH
`define PRICE_LEVEL_ORDER_BOOK_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PLOB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PLOB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/plob_pkg.sv */
// ----------------------------------------------------------------------------
// plob_pkg
// Types, codes and helpers of the price level order book.
// ----------------------------------------------------------------------------
package plob_pkg;

	localparam int PLOB_LEVELS = 64;
	localparam int PRICE_W     = 32;
	localparam int VOL_W       = 48;
	localparam int CUM_W       = 54;
	localparam int KIND_W      = 3;
	localparam int STAT_W      = 3;
	localparam int DEPTH_W     = 7;
	localparam int MAX_RES     = 64;
	localparam int DEPTH_RST   = 64;
	localparam int IN_DATA_W   = 80;
	localparam int OUT_DATA_W  = 88;

	typedef enum logic [KIND_W-1:0] {
		K_BID_UPD  = 3'd0,
		K_ASK_UPD  = 3'd1,
		K_BID_SNAP = 3'd2,
		K_ASK_SNAP = 3'd3,
		K_QRY_BID  = 3'd4,
		K_QRY_ASK  = 3'd5
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_STORED  = 3'd0,
		ST_REMOVED = 3'd1,
		ST_DROPPED = 3'd2,
		ST_QUERY   = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_EVAL,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_WRITE,
		CELL_ROTATE
	} cell_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_DECIDE,
		S_QPREP,
		S_SUM,
		S_EMIT,
		S_EMPTY
	} state_t;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [VOL_W-1:0]   vol;
	} cell_data_t;

	typedef struct packed {
		logic upd;
		logic query;
		logic ask;
		logic rm_zero;
	} kind_info_t;

	function automatic kind_info_t decode_kind(logic [KIND_W-1:0] k);
		kind_info_t r;
		r = '0;
		unique case (k) inside
			K_BID_UPD:  begin r.upd = 1'b1; r.rm_zero = 1'b1; end
			K_ASK_UPD:  begin r.upd = 1'b1; r.rm_zero = 1'b1; r.ask = 1'b1; end
			K_BID_SNAP: r.upd = 1'b1;
			K_ASK_SNAP: begin r.upd = 1'b1; r.ask = 1'b1; end
			K_QRY_BID:  r.query = 1'b1;
			K_QRY_ASK:  begin r.query = 1'b1; r.ask = 1'b1; end
			default:    r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [CUM_W-1:0] sat_add(logic [CUM_W-1:0] a, logic [VOL_W-1:0] b);
		logic [CUM_W:0] s;
		s = {1'b0, a} + (CUM_W + 1)'(b);
		return s[CUM_W] ? '1 : s[CUM_W-1:0];
	endfunction

endpackage

/* hw/rtl/plob_cell.sv */
// ----------------------------------------------------------------------------
// plob_cell
// One price level slot: compares against the request price and shifts.
// ----------------------------------------------------------------------------
module plob_cell import plob_pkg::*; #(
	parameter int LEVELS = PLOB_LEVELS,
	parameter int IDX    = 0,
	localparam int CW    = $clog2(LEVELS + 1)
) (
	input  logic               clk,
	input  cell_op_t           op,
	input  logic [CW-1:0]      count,
	input  logic [PRICE_W-1:0] key_price,
	input  logic [VOL_W-1:0]   key_vol,
	input  cell_data_t         left_data,
	input  logic               left_lt,
	input  cell_data_t         right_data,
	output cell_data_t         data,
	output logic               lt,
	output logic               eq
);

	cell_data_t data_q;
	logic       lt_q;
	logic       eq_q;
	logic       occ;

	assign occ = CW'(IDX) < count;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_EVAL: begin
				lt_q <= occ && (data_q.price < key_price);
				eq_q <= occ && (data_q.price == key_price);
			end
			CELL_INSERT: begin
				if (!lt_q) begin
					if (left_lt) begin
						data_q.price <= key_price;
						data_q.vol   <= key_vol;
					end else begin
						data_q <= left_data;
					end
				end
			end
			CELL_REMOVE: begin
				if (!lt_q)
					data_q <= right_data;
			end
			CELL_WRITE: begin
				if (eq_q)
					data_q.vol <= key_vol;
			end
			CELL_ROTATE: data_q <= right_data;
			default: data_q <= data_q;
		endcase
	end

	assign data = data_q;
	assign lt   = lt_q;
	assign eq   = eq_q;

endmodule

/* hw/rtl/plob_chain.sv */
// ----------------------------------------------------------------------------
// plob_chain
// Ring of level cells for one book side, held in ascending price order.
// ----------------------------------------------------------------------------
module plob_chain import plob_pkg::*; #(
	parameter int LEVELS = PLOB_LEVELS,
	localparam int CW    = $clog2(LEVELS + 1)
) (
	input  logic               clk,
	input  cell_op_t           op,
	input  logic [CW-1:0]      count,
	input  logic [PRICE_W-1:0] key_price,
	input  logic [VOL_W-1:0]   key_vol,
	output cell_data_t         head,
	output logic               found
);

	cell_data_t        cdata [LEVELS];
	logic [LEVELS-1:0] lt_vec;
	logic [LEVELS-1:0] eq_vec;

	for (genvar i = 0; i < LEVELS; i++) begin : g_cell
		localparam int L = (i == 0) ? 0 : i - 1;
		localparam int R = (i == LEVELS - 1) ? 0 : i + 1;

		plob_cell #(
			.LEVELS(LEVELS),
			.IDX   (i)
		) u_cell (
			.clk       (clk),
			.op        (op),
			.count     (count),
			.key_price (key_price),
			.key_vol   (key_vol),
			.left_data (cdata[L]),
			.left_lt   ((i == 0) ? 1'b1 : lt_vec[L]),
			.right_data(cdata[R]),
			.data      (cdata[i]),
			.lt        (lt_vec[i]),
			.eq        (eq_vec[i])
		);
	end

	assign head  = cdata[0];
	assign found = |eq_vec;

endmodule

/* hw/rtl/price_level_order_book.sv */
// ----------------------------------------------------------------------------
// price_level_order_book
// Bid and ask price level tables with cumulative depth queries.
// ----------------------------------------------------------------------------
// Each side is a ring of LEVELS cells kept in ascending price order. An update
// or snapshot request is accepted, compared in every cell, then applied as an
// in-place write or a shift of the cells once the result register is free. A
// query reads the ring out through cell 0 by rotating it one cell per cycle
// while the output is not held off: an ask query makes one turn that sums and
// emits, a bid query one turn to sum the window and a second to emit it.
// Requests are taken one at a time; the result register lets the next request
// in while the last result still waits.
module price_level_order_book import plob_pkg::*; #(
	parameter int LEVELS = PLOB_LEVELS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // price_ticks[31:0], volume_units[79:32]
	input  logic [KIND_W-1:0]     s_axis_tuser,  // kind[2:0]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // level_price[31:0], cumulative_volume[85:32]
	output logic [STAT_W-1:0]     m_axis_tuser,  // status[2:0]
	output logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [DEPTH_W-1:0]    cfg_data
);

	localparam int CW = $clog2(LEVELS + 1);
	localparam int IW = $clog2(LEVELS);
	localparam int NW = (CW > DEPTH_W) ? CW : DEPTH_W;

	state_t             state_q, state_d;
	logic [KIND_W-1:0]  kind_q;
	logic [PRICE_W-1:0] price_q;
	logic [VOL_W-1:0]   vol_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [CW-1:0]      bid_cnt_q, ask_cnt_q;
	logic [CW-1:0]      lo_q, hi_q;
	logic [IW-1:0]      step_q;
	logic [CUM_W-1:0]   acc_q, acc_d;

	logic               out_valid_q;
	logic [PRICE_W-1:0] out_price_q, out_price_d;
	logic [CUM_W-1:0]   out_cum_q, out_cum_d;
	status_t            out_status_q, out_status_d;
	logic               out_last_q, out_last_d;
	logic               load_out;
	logic               out_free;

	kind_info_t in_info, info;
	cell_op_t   side_op, bid_op, ask_op;
	cell_data_t bid_head, ask_head, head;
	logic       bid_found, ask_found, found;
	logic [CW-1:0] side_cnt;
	logic       cnt_inc, cnt_dec, step_adv;

	logic [DEPTH_W-1:0] depth_cl;
	logic [NW-1:0]      n_w;
	logic [CW-1:0]      n_c, lo_d;
	logic [CW-1:0]      step_ext;
	logic               in_win, is_last, step_end, advance;
	logic [CUM_W-1:0]   run_sum;

	assign in_info  = decode_kind(s_axis_tuser);
	assign info     = decode_kind(kind_q);
	assign side_cnt = info.ask ? ask_cnt_q : bid_cnt_q;
	assign found    = info.ask ? ask_found : bid_found;
	assign head     = info.ask ? ask_head : bid_head;
	assign out_free = !out_valid_q || m_axis_tready;

	assign depth_cl = (depth_q == '0) ? DEPTH_W'(1) :
	                  (depth_q > DEPTH_W'(MAX_RES)) ? DEPTH_W'(MAX_RES) : depth_q;
	assign n_w      = (NW'(side_cnt) < NW'(depth_cl)) ? NW'(side_cnt) : NW'(depth_cl);
	assign n_c      = CW'(n_w);
	assign lo_d     = info.ask ? '0 : side_cnt - n_c;

	assign step_ext = CW'(step_q);
	assign in_win   = (step_ext >= lo_q) && (step_ext < hi_q);
	assign is_last  = step_ext == (hi_q - CW'(1));
	assign step_end = step_q == IW'(LEVELS - 1);
	assign advance  = !in_win || out_free;
	assign run_sum  = sat_add(acc_q, head.vol);

	assign bid_op = info.ask ? CELL_HOLD : side_op;
	assign ask_op = info.ask ? side_op : CELL_HOLD;

	plob_chain #(.LEVELS(LEVELS)) u_bid (
		.clk      (clk),
		.op       (bid_op),
		.count    (bid_cnt_q),
		.key_price(price_q),
		.key_vol  (vol_q),
		.head     (bid_head),
		.found    (bid_found)
	);

	plob_chain #(.LEVELS(LEVELS)) u_ask (
		.clk      (clk),
		.op       (ask_op),
		.count    (ask_cnt_q),
		.key_price(price_q),
		.key_vol  (vol_q),
		.head     (ask_head),
		.found    (ask_found)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					if (in_info.upd)
						state_d = S_EVAL;
					else if (in_info.query)
						state_d = S_QPREP;
				end
			end
			S_EVAL:   state_d = S_DECIDE;
			S_DECIDE: if (out_free) state_d = S_IDLE;
			S_QPREP: begin
				if (side_cnt == '0)
					state_d = S_EMPTY;
				else
					state_d = info.ask ? S_EMIT : S_SUM;
			end
			S_SUM:    if (step_end) state_d = S_EMIT;
			S_EMIT:   if (step_end && advance) state_d = S_IDLE;
			S_EMPTY:  if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		side_op       = CELL_HOLD;
		load_out      = 1'b0;
		out_price_d   = price_q;
		out_cum_d     = '0;
		out_status_d  = ST_STORED;
		out_last_d    = 1'b1;
		cnt_inc       = 1'b0;
		cnt_dec       = 1'b0;
		step_adv      = 1'b0;
		acc_d         = acc_q;
		unique case (state_q)
			S_IDLE: s_axis_tready = 1'b1;
			S_EVAL: side_op = CELL_EVAL;
			S_DECIDE: begin
				if (out_free) begin
					load_out = 1'b1;
					if (info.rm_zero && (vol_q == '0)) begin
						out_status_d = ST_REMOVED;
						if (found) begin
							side_op = CELL_REMOVE;
							cnt_dec = 1'b1;
						end
					end else if (found) begin
						side_op   = CELL_WRITE;
						out_cum_d = CUM_W'(vol_q);
					end else if (side_cnt == CW'(LEVELS)) begin
						out_status_d = ST_DROPPED;
					end else begin
						side_op   = CELL_INSERT;
						cnt_inc   = 1'b1;
						out_cum_d = CUM_W'(vol_q);
					end
				end
			end
			S_QPREP: acc_d = '0;
			S_SUM: begin
				side_op  = CELL_ROTATE;
				step_adv = 1'b1;
				if (in_win)
					acc_d = run_sum;
			end
			S_EMIT: begin
				if (advance) begin
					side_op  = CELL_ROTATE;
					step_adv = 1'b1;
				end
				if (in_win && out_free) begin
					load_out     = 1'b1;
					out_price_d  = head.price;
					out_status_d = ST_QUERY;
					out_last_d   = is_last;
					if (info.ask) begin
						out_cum_d = run_sum;
						acc_d     = run_sum;
					end else begin
						out_cum_d = acc_q;
						acc_d     = acc_q - CUM_W'(head.vol);
					end
				end
			end
			S_EMPTY: begin
				if (out_free) begin
					load_out     = 1'b1;
					out_price_d  = '0;
					out_status_d = ST_EMPTY;
				end
			end
			default: side_op = CELL_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= DEPTH_W'(DEPTH_RST);
			bid_cnt_q   <= '0;
			ask_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid)
				depth_q <= cfg_data;
			if (cnt_inc || cnt_dec) begin
				if (info.ask)
					ask_cnt_q <= cnt_inc ? ask_cnt_q + CW'(1) : ask_cnt_q - CW'(1);
				else
					bid_cnt_q <= cnt_inc ? bid_cnt_q + CW'(1) : bid_cnt_q - CW'(1);
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_q  <= s_axis_tuser;
			price_q <= s_axis_tdata[PRICE_W-1:0];
			vol_q   <= s_axis_tdata[PRICE_W+VOL_W-1:PRICE_W];
		end
		if (state_q == S_QPREP) begin
			lo_q   <= lo_d;
			hi_q   <= lo_d + n_c;
			step_q <= '0;
		end else if (step_adv) begin
			step_q <= step_end ? '0 : step_q + IW'(1);
		end
		acc_q <= acc_d;
		if (load_out) begin
			out_price_q  <= out_price_d;
			out_cum_q    <= out_cum_d;
			out_status_q <= out_status_d;
			out_last_q   <= out_last_d;
		end
	end

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W - CUM_W - PRICE_W)'(0), out_cum_q, out_price_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

endmodule

/* hw/rtl/plob_chk.sv */
// ----------------------------------------------------------------------------
// plob_chk
// Port-level checks on the order book result stream.
// ----------------------------------------------------------------------------
`include "price_level_order_book_defines.svh"

module plob_chk import plob_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [STAT_W-1:0]     m_axis_tuser,
	input logic                  m_axis_tlast
);

	`PLOB_ASSERT_NOW(a_single_last, m_axis_tvalid && (m_axis_tuser != ST_QUERY), m_axis_tlast, "non-query result without tlast")
	`PLOB_ASSERT_NOW(a_empty_zero, m_axis_tvalid && (m_axis_tuser == ST_EMPTY), m_axis_tdata == '0, "empty side result carries data")
	`PLOB_ASSERT_NOW(a_nocum_zero, m_axis_tvalid && (m_axis_tuser == ST_REMOVED || m_axis_tuser == ST_DROPPED), m_axis_tdata[OUT_DATA_W-1:PRICE_W] == '0, "removed or dropped result has volume")
	`PLOB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind price_level_order_book plob_chk u_plob_chk (.*);
